FILE: sv/selective_repeat_arq_sender_unit_defines.svh
// assertion macros for the selective-repeat arq sender
`ifndef SELECTIVE_REPEAT_ARQ_SENDER_UNIT_DEFINES_SVH
`define SELECTIVE_REPEAT_ARQ_SENDER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SRARQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srarq assertion failed");

// next-cycle implication, checked outside reset
`define SRARQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srarq assertion failed");

`endif

FILE: sv/srarq_pkg.sv
// shared types and constants of the selective-repeat arq sender
package srarq_pkg;

  localparam int FRAME_W        = 16;
  localparam int CNT_W          = 32;
  localparam int WSIZE_W        = 5;
  localparam int ACKS_W         = 5;
  localparam int KIND_W         = 2;
  localparam int REQ_W          = 2;
  localparam int MARK_W         = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int WINDOW_MAX_DEF = 16;
  localparam int CMDQ_DEPTH     = 2;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd4;
  localparam logic [ACKS_W-1:0]  ACKS_MAX    = '1;

  localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NEW    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  localparam logic [MARK_W-1:0] MARK_UNSENT = 2'd0;
  localparam logic [MARK_W-1:0] MARK_SENT   = 2'd1;
  localparam logic [MARK_W-1:0] MARK_ACKED  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'd1;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_ACK,
    CMD_TIMEOUT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [FRAME_W-1:0]   ack;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLIDE_RD,
    ST_SLIDE_CHK,
    ST_PHASE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FLUSH
  } st_t;

endpackage

FILE: sv/srarq_front.sv
// front end: takes requests, decodes them and queues commands for the back end
module srarq_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [srarq_pkg::REQ_W-1:0]      in_req_type,
  input  logic [srarq_pkg::FRAME_W-1:0]    in_ack_number,
  output srarq_pkg::cmd_t                  cmd,
  output logic                             cmd_valid,
  input  logic                             cmd_pop
);

  localparam int DEPTH = srarq_pkg::CMDQ_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  srarq_pkg::cmd_t q_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  srarq_pkg::cmd_kind_t dec_kind;
  logic                 dec_known;
  logic                 enq;
  logic                 deq;

  always_comb begin
    dec_kind  = srarq_pkg::CMD_START;
    dec_known = 1'b1;
    case (in_req_type)
      srarq_pkg::REQ_START: begin
        dec_kind = srarq_pkg::CMD_START;
      end
      srarq_pkg::REQ_ACK: begin
        dec_kind = srarq_pkg::CMD_ACK;
      end
      srarq_pkg::REQ_TIMEOUT: begin
        dec_kind = srarq_pkg::CMD_TIMEOUT;
      end
      default: begin
        dec_known = 1'b0;
      end
    endcase
  end

  assign in_stall  = (cnt_r == CW'(DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign enq       = in_valid && !in_stall && dec_known;
  assign deq       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({enq, deq})
      2'b10: begin
        cnt_nxt = cnt_r + 1'b1;
      end
      2'b01: begin
        cnt_nxt = cnt_r - 1'b1;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r].kind <= dec_kind;
      q_r[wr_ptr_r].ack  <= in_ack_number;
    end
  end

endmodule

FILE: sv/srarq_back.sv
// back end: window state, slot mark memory, phase scans and result staging
module srarq_back #(
  parameter int WINDOW_MAX = srarq_pkg::WINDOW_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [srarq_pkg::FRAME_W-1:0]    total_frames,
  input  logic [srarq_pkg::WSIZE_W-1:0]    window_size,
  input  srarq_pkg::cmd_t                  cmd,
  input  logic                             cmd_valid,
  output logic                             cmd_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [srarq_pkg::FRAME_W-1:0]    out_frame_number,
  output logic [srarq_pkg::KIND_W-1:0]     out_send_kind,
  output logic                             out_last,
  output logic [srarq_pkg::CNT_W-1:0]      out_sent_total,
  output logic [srarq_pkg::CNT_W-1:0]      out_lost_total,
  output logic [srarq_pkg::CNT_W-1:0]      out_resent_total
);

  localparam int FW = srarq_pkg::FRAME_W;
  localparam int NW = srarq_pkg::CNT_W;
  localparam int KW = srarq_pkg::KIND_W;
  localparam int MW = srarq_pkg::MARK_W;
  localparam int AW = srarq_pkg::ACKS_W;
  localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int WW = $clog2(WINDOW_MAX + 1);
  localparam int EW = (WW > srarq_pkg::WSIZE_W) ? WW : srarq_pkg::WSIZE_W;
  localparam logic [SW:0] WM_S = (SW + 1)'(WINDOW_MAX);

  function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
    logic [SW:0] t;
    t = {1'b0, s} + 1'b1;
    return (t == WM_S) ? '0 : t[SW-1:0];
  endfunction

  function automatic logic [NW-1:0] sat_inc(input logic [NW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  srarq_pkg::st_t state_r, state_nxt;

  logic [FW-1:0] base_r, base_nxt;
  logic [SW-1:0] base_slot_r, base_slot_nxt;
  logic [AW-1:0] acks_r, acks_nxt;
  logic          active_r, active_nxt;
  logic [NW-1:0] sent_r, sent_nxt;
  logic [NW-1:0] lost_r, lost_nxt;
  logic [NW-1:0] resent_r, resent_nxt;
  logic [WW-1:0] i_r, i_nxt;
  logic [SW-1:0] scan_slot_r, scan_slot_nxt;
  logic          pass_new_r, pass_new_nxt;

  logic          pend_vld_r, pend_vld_nxt;
  logic [FW-1:0] pend_frame_r, pend_frame_nxt;
  logic [KW-1:0] pend_kind_r, pend_kind_nxt;
  logic [NW-1:0] pend_sent_r, pend_sent_nxt;
  logic [NW-1:0] pend_lost_r, pend_lost_nxt;
  logic [NW-1:0] pend_resent_r, pend_resent_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [FW-1:0] out_frame_r, out_frame_nxt;
  logic [KW-1:0] out_kind_r, out_kind_nxt;
  logic          out_last_r, out_last_nxt;
  logic [NW-1:0] out_sent_r, out_sent_nxt;
  logic [NW-1:0] out_lost_r, out_lost_nxt;
  logic [NW-1:0] out_resent_r, out_resent_nxt;

  // slot mark memory with per-slot valid bits
  logic [MW-1:0]         mark_mem [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] vld_r;
  logic [MW-1:0]         rd_data_r;
  logic                  rd_vld_r;

  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic          mem_re;
  logic [SW-1:0] mem_raddr;
  logic          vld_clr_all;
  logic          vld_clr;

  logic          emit;
  logic [FW-1:0] emit_frame;
  logic [KW-1:0] emit_kind;

  logic [EW-1:0] ws_e;
  logic [WW-1:0] w;
  logic [EW-1:0] diff_e;
  logic          acks_lt_w;
  logic          base_done;
  logic          phase_due;
  logic [FW-1:0] d16;
  logic          in_win;
  logic [SW:0]   slot_sum;
  logic [SW:0]   slot_fix;
  logic [SW-1:0] slot_ack;
  logic [FW:0]   f17;
  logic          scan_end;
  logic [MW-1:0] mark;
  logic          hit;
  logic          out_free;
  logic          can_emit;
  logic [NW:0]   lost_sum;

  always_comb begin
    ws_e = EW'(window_size);
    if (ws_e == '0) begin
      w = WW'(1);
    end else if (ws_e > EW'(WINDOW_MAX)) begin
      w = WW'(WINDOW_MAX);
    end else begin
      w = ws_e[WW-1:0];
    end
  end

  assign diff_e    = EW'(w) - EW'(acks_r);
  assign acks_lt_w = EW'(acks_r) < EW'(w);
  assign base_done = base_r >= total_frames;
  assign phase_due = !acks_lt_w || base_done;
  assign lost_sum  = {1'b0, lost_r} + (NW + 1)'(diff_e);

  assign d16      = cmd.ack - base_r;
  assign in_win   = (cmd.ack < total_frames) && (cmd.ack >= base_r) && (d16 < FW'(w));
  assign slot_sum = {1'b0, base_slot_r} + {1'b0, d16[SW-1:0]};
  assign slot_fix = (slot_sum >= WM_S) ? slot_sum - WM_S : slot_sum;
  assign slot_ack = slot_fix[SW-1:0];

  assign f17      = {1'b0, base_r} + (FW + 1)'(i_r);
  assign scan_end = (i_r == w) || (f17 >= {1'b0, total_frames});
  assign mark     = rd_vld_r ? rd_data_r : srarq_pkg::MARK_UNSENT;
  assign hit      = pass_new_r ? (mark == srarq_pkg::MARK_UNSENT) :
                                 (mark == srarq_pkg::MARK_SENT);
  assign out_free = !out_valid_r || !out_stall;
  assign can_emit = !pend_vld_r || out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srarq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            srarq_pkg::CMD_START: begin
              state_nxt = srarq_pkg::ST_PHASE;
            end
            srarq_pkg::CMD_ACK: begin
              state_nxt = active_r ? srarq_pkg::ST_SLIDE_RD : srarq_pkg::ST_IDLE;
            end
            srarq_pkg::CMD_TIMEOUT: begin
              state_nxt = active_r ? srarq_pkg::ST_PHASE : srarq_pkg::ST_IDLE;
            end
            default: begin
              state_nxt = srarq_pkg::ST_IDLE;
            end
          endcase
        end
      end
      srarq_pkg::ST_SLIDE_RD: begin
        state_nxt = base_done ? srarq_pkg::ST_PHASE : srarq_pkg::ST_SLIDE_CHK;
      end
      srarq_pkg::ST_SLIDE_CHK: begin
        if (mark == srarq_pkg::MARK_ACKED) begin
          state_nxt = srarq_pkg::ST_SLIDE_RD;
        end else begin
          state_nxt = phase_due ? srarq_pkg::ST_PHASE : srarq_pkg::ST_IDLE;
        end
      end
      srarq_pkg::ST_PHASE: begin
        if (!base_done) begin
          state_nxt = srarq_pkg::ST_SCAN_RD;
        end else if (can_emit) begin
          state_nxt = srarq_pkg::ST_FLUSH;
        end
      end
      srarq_pkg::ST_SCAN_RD: begin
        if (!scan_end) begin
          state_nxt = srarq_pkg::ST_SCAN_CHK;
        end else if (pass_new_r) begin
          state_nxt = srarq_pkg::ST_FLUSH;
        end
      end
      srarq_pkg::ST_SCAN_CHK: begin
        if (!hit || can_emit) begin
          state_nxt = srarq_pkg::ST_SCAN_RD;
        end
      end
      srarq_pkg::ST_FLUSH: begin
        if (!pend_vld_r || out_free) begin
          state_nxt = srarq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srarq_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and control outputs
  always_comb begin
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = scan_slot_r;
    mem_wdata     = srarq_pkg::MARK_SENT;
    mem_re        = 1'b0;
    mem_raddr     = scan_slot_r;
    vld_clr_all   = 1'b0;
    vld_clr       = 1'b0;
    emit          = 1'b0;
    emit_frame    = f17[FW-1:0];
    emit_kind     = srarq_pkg::KIND_NEW;

    base_nxt      = base_r;
    base_slot_nxt = base_slot_r;
    acks_nxt      = acks_r;
    active_nxt    = active_r;
    sent_nxt      = sent_r;
    lost_nxt      = lost_r;
    resent_nxt    = resent_r;
    i_nxt         = i_r;
    scan_slot_nxt = scan_slot_r;
    pass_new_nxt  = pass_new_r;

    pend_vld_nxt    = pend_vld_r;
    pend_frame_nxt  = pend_frame_r;
    pend_kind_nxt   = pend_kind_r;
    pend_sent_nxt   = pend_sent_r;
    pend_lost_nxt   = pend_lost_r;
    pend_resent_nxt = pend_resent_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_frame_nxt  = out_frame_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    out_sent_nxt   = out_sent_r;
    out_lost_nxt   = out_lost_r;
    out_resent_nxt = out_resent_r;

    case (state_r)
      srarq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            srarq_pkg::CMD_START: begin
              vld_clr_all   = 1'b1;
              base_nxt      = '0;
              base_slot_nxt = '0;
              acks_nxt      = '0;
              active_nxt    = 1'b1;
              sent_nxt      = '0;
              lost_nxt      = '0;
              resent_nxt    = '0;
            end
            srarq_pkg::CMD_ACK: begin
              if (active_r) begin
                if (in_win) begin
                  mem_we    = 1'b1;
                  mem_waddr = slot_ack;
                  mem_wdata = srarq_pkg::MARK_ACKED;
                end
                if (acks_r != srarq_pkg::ACKS_MAX) begin
                  acks_nxt = acks_r + 1'b1;
                end
              end
            end
            srarq_pkg::CMD_TIMEOUT: begin
              if (active_r && acks_lt_w) begin
                lost_nxt = lost_sum[NW] ? '1 : lost_sum[NW-1:0];
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      srarq_pkg::ST_SLIDE_RD: begin
        if (!base_done) begin
          mem_re    = 1'b1;
          mem_raddr = base_slot_r;
        end
      end
      srarq_pkg::ST_SLIDE_CHK: begin
        if (mark == srarq_pkg::MARK_ACKED) begin
          vld_clr       = 1'b1;
          base_nxt      = base_r + 1'b1;
          base_slot_nxt = slot_next(base_slot_r);
        end
      end
      srarq_pkg::ST_PHASE: begin
        acks_nxt      = '0;
        i_nxt         = '0;
        scan_slot_nxt = base_slot_r;
        pass_new_nxt  = 1'b0;
        if (base_done && can_emit) begin
          emit       = 1'b1;
          emit_frame = '0;
          emit_kind  = srarq_pkg::KIND_END;
          active_nxt = 1'b0;
        end
      end
      srarq_pkg::ST_SCAN_RD: begin
        if (!scan_end) begin
          mem_re    = 1'b1;
          mem_raddr = scan_slot_r;
        end else if (!pass_new_r) begin
          pass_new_nxt  = 1'b1;
          i_nxt         = '0;
          scan_slot_nxt = base_slot_r;
        end
      end
      srarq_pkg::ST_SCAN_CHK: begin
        if (!hit || can_emit) begin
          i_nxt         = i_r + 1'b1;
          scan_slot_nxt = slot_next(scan_slot_r);
        end
        if (hit && can_emit) begin
          emit = 1'b1;
          if (pass_new_r) begin
            emit_kind = srarq_pkg::KIND_NEW;
            mem_we    = 1'b1;
            mem_waddr = scan_slot_r;
            mem_wdata = srarq_pkg::MARK_SENT;
            sent_nxt  = sat_inc(sent_r);
          end else begin
            emit_kind  = srarq_pkg::KIND_RESEND;
            resent_nxt = sat_inc(resent_r);
          end
        end
      end
      srarq_pkg::ST_FLUSH: begin
        if (pend_vld_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_frame_nxt  = pend_frame_r;
          out_kind_nxt   = pend_kind_r;
          out_last_nxt   = 1'b1;
          out_sent_nxt   = pend_sent_r;
          out_lost_nxt   = pend_lost_r;
          out_resent_nxt = pend_resent_r;
          pend_vld_nxt   = 1'b0;
        end
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase

    // one result is held back so that the final one can carry last
    if (emit) begin
      if (pend_vld_r) begin
        out_valid_nxt  = 1'b1;
        out_frame_nxt  = pend_frame_r;
        out_kind_nxt   = pend_kind_r;
        out_last_nxt   = 1'b0;
        out_sent_nxt   = pend_sent_r;
        out_lost_nxt   = pend_lost_r;
        out_resent_nxt = pend_resent_r;
      end
      pend_vld_nxt    = 1'b1;
      pend_frame_nxt  = emit_frame;
      pend_kind_nxt   = emit_kind;
      pend_sent_nxt   = sent_nxt;
      pend_lost_nxt   = lost_nxt;
      pend_resent_nxt = resent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srarq_pkg::ST_IDLE;
      base_r      <= '0;
      base_slot_r <= '0;
      acks_r      <= '0;
      active_r    <= 1'b0;
      sent_r      <= '0;
      lost_r      <= '0;
      resent_r    <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      base_slot_r <= base_slot_nxt;
      acks_r      <= acks_nxt;
      active_r    <= active_nxt;
      sent_r      <= sent_nxt;
      lost_r      <= lost_nxt;
      resent_r    <= resent_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r           <= i_nxt;
    scan_slot_r   <= scan_slot_nxt;
    pass_new_r    <= pass_new_nxt;
    pend_frame_r  <= pend_frame_nxt;
    pend_kind_r   <= pend_kind_nxt;
    pend_sent_r   <= pend_sent_nxt;
    pend_lost_r   <= pend_lost_nxt;
    pend_resent_r <= pend_resent_nxt;
    out_frame_r   <= out_frame_nxt;
    out_kind_r    <= out_kind_nxt;
    out_last_r    <= out_last_nxt;
    out_sent_r    <= out_sent_nxt;
    out_lost_r    <= out_lost_nxt;
    out_resent_r  <= out_resent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (vld_clr_all) begin
      vld_r <= '0;
    end else begin
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      if (vld_clr) begin
        vld_r[base_slot_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mark_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mark_mem[mem_raddr];
      rd_vld_r  <= vld_r[mem_raddr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_number = out_frame_r;
  assign out_send_kind    = out_kind_r;
  assign out_last         = out_last_r;
  assign out_sent_total   = out_sent_r;
  assign out_lost_total   = out_lost_r;
  assign out_resent_total = out_resent_r;

endmodule

FILE: sv/selective_repeat_arq_sender_unit.sv
// top level of the selective-repeat arq sender: configuration registers, front and back ends
// Requests (start, ack, timeout) enter through a two-entry command queue, so up to two can be
// taken while earlier ones are still worked on; a request code of 3 is taken and dropped. The
// back end handles one command at a time. An ack that ends no phase reads and checks the slot
// mark of each frame the window base slides past; a phase end makes two passes over the window
// (retransmissions, then new frames), each of which reads the slot mark memory through its
// single registered read port, reading each slot in one state and checking it in the next.
// Results leave through an output register; one result is held back internally so the final
// one of a request carries last. Slot marks are cleared at once by per-slot valid bits, so
// there is no clearing pass.
`include "selective_repeat_arq_sender_unit_defines.svh"

module selective_repeat_arq_sender_unit #(
  parameter int WINDOW_MAX = srarq_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [srarq_pkg::REQ_W-1:0]         in_req_type,
  input  logic [srarq_pkg::FRAME_W-1:0]       in_ack_number,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [srarq_pkg::FRAME_W-1:0]       out_frame_number,
  output logic [srarq_pkg::KIND_W-1:0]        out_send_kind,
  output logic                                out_last,
  output logic [srarq_pkg::CNT_W-1:0]         out_sent_total,
  output logic [srarq_pkg::CNT_W-1:0]         out_lost_total,
  output logic [srarq_pkg::CNT_W-1:0]         out_resent_total,
  input  logic                                cfg_we,
  input  logic [srarq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srarq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [srarq_pkg::FRAME_W-1:0] total_frames_r;
  logic [srarq_pkg::WSIZE_W-1:0] window_size_r;

  srarq_pkg::cmd_t cmd;
  logic            cmd_valid;
  logic            cmd_pop;

  logic            out_is_end;
  logic            out_is_resend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_frames_r <= '0;
      window_size_r  <= srarq_pkg::WSIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        srarq_pkg::CFG_TOTAL_FRAMES: begin
          total_frames_r <= cfg_wdata[srarq_pkg::FRAME_W-1:0];
        end
        srarq_pkg::CFG_WINDOW_SIZE: begin
          window_size_r <= cfg_wdata[srarq_pkg::WSIZE_W-1:0];
        end
        default: begin
          total_frames_r <= total_frames_r;
        end
      endcase
    end
  end

  srarq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_ack_number (in_ack_number),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop)
  );

  srarq_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .total_frames     (total_frames_r),
    .window_size      (window_size_r),
    .cmd              (cmd),
    .cmd_valid        (cmd_valid),
    .cmd_pop          (cmd_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_number (out_frame_number),
    .out_send_kind    (out_send_kind),
    .out_last         (out_last),
    .out_sent_total   (out_sent_total),
    .out_lost_total   (out_lost_total),
    .out_resent_total (out_resent_total)
  );

  assign out_is_end    = out_valid && (out_send_kind == srarq_pkg::KIND_END);
  assign out_is_resend = out_valid && (out_send_kind == srarq_pkg::KIND_RESEND);

  `SRARQ_ASSERT_IMP(a_pop_needs_cmd, cmd_pop, cmd_valid)
  `SRARQ_ASSERT_NXT(a_cmd_kept, cmd_valid && !cmd_pop, cmd_valid)
  `SRARQ_ASSERT_IMP(a_end_is_last, out_is_end, out_last && out_frame_number == '0)
  `SRARQ_ASSERT_IMP(a_resend_counted, out_is_resend, out_resent_total != '0)

endmodule
